[rtl/assert_macros.svh]
// Assertion macros used by the RTL top module.
// Both forms sample on the rising edge; ASSERT_CLK is muted during reset and ASSERT_CLK_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/frf_pkg.sv]
package frf_pkg;

  // Default structure parameters
  localparam int MAX_FRAME_DEF    = 32;
  localparam int HEADER_COUNT_DEF = 5;

  // Fixed field widths
  localparam int POS_W  = 6;
  localparam int LEN_W  = 8;
  localparam int TICK_W = 16;
  localparam int RUN_W  = 3;
  localparam int PLEN_W = 6;

  // Framing constants
  localparam logic [7:0] HDR_CHAR   = 8'h23;
  localparam logic [7:0] BROADCAST  = 8'hFF;
  localparam logic [7:0] MIN_LEN    = 8'd4;
  localparam logic [LEN_W-1:0] OVERHEAD = 8'd4;

  // Register reset values
  localparam logic [7:0]  OWN_ADDR_RST = 8'd0;
  localparam logic [5:0]  MIN_LEN_RST  = 6'd4;
  localparam logic [5:0]  MAX_LEN_RST  = 6'd32;
  localparam logic [15:0] TIMEOUT_RST  = 16'd100;

  // Register indexes
  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_MIN_LEN  = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Closing status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOT_HERE = 3'd1;
  localparam logic [2:0] STAT_LEN_ERR  = 3'd2;
  localparam logic [2:0] STAT_SUM_ERR  = 3'd3;
  localparam logic [2:0] STAT_TIMEOUT  = 3'd4;

  typedef enum logic {
    PH_WAIT,
    PH_READ
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_STATUS
  } state_t;

endpackage

[rtl/frf_ram.sv]
module frf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/frame_receiver_with_address_filter_top.sv]
// A closing status item that follows no payload run is registered in the cycle after the transaction that ends it.
// Throughput: one input transaction per cycle while no payload run is being emitted and the output is not stalled.
// A payload run walks the frame store RAM: a read state and a load state per payload byte,
// then a status state for the closing status; input is held off until the run ends.
// Reset: synchronous, active high; control and configuration registers return to defaults, no RAM clearing pass.
`include "assert_macros.svh"

module frame_receiver_with_address_filter_top #(
  parameter int MAX_FRAME    = frf_pkg::MAX_FRAME_DEF,
  parameter int HEADER_COUNT = frf_pkg::HEADER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        is_payload,
  output logic [7:0]  src_address,
  output logic [7:0]  dest_address,
  output logic [4:0]  payload_length,
  output logic [2:0]  frame_status,
  output logic        last
);

  localparam int StoreDepth = MAX_FRAME - 1;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam logic [frf_pkg::LEN_W-1:0] MaxLen = frf_pkg::LEN_W'(MAX_FRAME);
  localparam logic [frf_pkg::RUN_W-1:0] HdrCount = frf_pkg::RUN_W'(HEADER_COUNT);
  localparam logic [frf_pkg::POS_W-1:0] StoreDepthPos = frf_pkg::POS_W'(StoreDepth);

  // Configuration registers
  logic [7:0]  own_address;
  logic [5:0]  min_frame_len;
  logic [5:0]  max_frame_len;
  logic [15:0] timeout_ticks;

  // Control state
  frf_pkg::state_t state, state_next;
  frf_pkg::phase_t phase, phase_next;
  logic [frf_pkg::RUN_W-1:0]  header_run, header_run_next;
  logic [frf_pkg::LEN_W-1:0]  frame_length, frame_length_next;
  logic [frf_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]                 running_sum, running_sum_next;
  logic [frf_pkg::TICK_W-1:0] tick_count, tick_count_next;
  logic [AddrW-1:0]           rd_addr, rd_addr_next;
  logic [frf_pkg::PLEN_W-1:0] emit_count, emit_count_next;
  logic                       out_valid_next;

  // Frame header fields and output payload
  logic [7:0]                 src_reg, src_reg_next;
  logic [7:0]                 dst_reg, dst_reg_next;
  logic [frf_pkg::PLEN_W-1:0] plen_reg, plen_reg_next;
  logic                       load_out;
  logic [7:0]                 payload_byte_next;
  logic                       is_payload_next;
  logic [7:0]                 src_address_next;
  logic [7:0]                 dest_address_next;
  logic [4:0]                 payload_length_next;
  logic [2:0]                 frame_status_next;
  logic                       last_next;

  // RAM port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  // Decode helpers
  logic                       in_take;
  logic                       out_free;
  logic                       cfg_write;
  logic [frf_pkg::LEN_W-1:0]  len_lo;
  logic [frf_pkg::LEN_W-1:0]  len_hi;
  logic [frf_pkg::POS_W-1:0]  store_idx;
  logic [frf_pkg::POS_W-1:0]  pos_inc;
  logic [frf_pkg::TICK_W-1:0] tick_inc;
  logic [frf_pkg::PLEN_W-1:0] plen_calc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == frf_pkg::ST_IDLE) && out_free;
  assign in_take   = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= frf_pkg::OWN_ADDR_RST;
      min_frame_len <= frf_pkg::MIN_LEN_RST;
      max_frame_len <= frf_pkg::MAX_LEN_RST;
      timeout_ticks <= frf_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        frf_pkg::REG_OWN_ADDR: own_address   <= pwdata[7:0];
        frf_pkg::REG_MIN_LEN:  min_frame_len <= pwdata[5:0];
        frf_pkg::REG_MAX_LEN:  max_frame_len <= pwdata[5:0];
        frf_pkg::REG_TIMEOUT:  timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[3:2])
      frf_pkg::REG_OWN_ADDR: prdata = {24'd0, own_address};
      frf_pkg::REG_MIN_LEN:  prdata = {26'd0, min_frame_len};
      frf_pkg::REG_MAX_LEN:  prdata = {26'd0, max_frame_len};
      frf_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_ticks};
      default:               prdata = 32'd0;
    endcase
  end

  // Clamp the allowed length window
  assign len_lo = ({2'b00, min_frame_len} < frf_pkg::MIN_LEN) ? frf_pkg::MIN_LEN
                                                              : {2'b00, min_frame_len};
  assign len_hi = ({2'b00, max_frame_len} > MaxLen) ? MaxLen : {2'b00, max_frame_len};

  assign store_idx = byte_position - 1'b1;
  assign pos_inc   = byte_position + 1'b1;
  assign tick_inc  = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign plen_calc = frf_pkg::PLEN_W'(frame_length - frf_pkg::OVERHEAD);
  assign ram_waddr = store_idx[AddrW-1:0];

  // Next state, frame parsing and output loading
  always_comb begin
    state_next          = state;
    phase_next          = phase;
    header_run_next     = header_run;
    frame_length_next   = frame_length;
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    tick_count_next     = tick_count;
    rd_addr_next        = rd_addr;
    emit_count_next     = emit_count;
    src_reg_next        = src_reg;
    dst_reg_next        = dst_reg;
    plen_reg_next       = plen_reg;
    out_valid_next      = out_valid && !out_ready;
    load_out            = 1'b0;
    payload_byte_next   = 8'd0;
    is_payload_next     = 1'b0;
    src_address_next    = 8'd0;
    dest_address_next   = 8'd0;
    payload_length_next = 5'd0;
    frame_status_next   = frf_pkg::STAT_OK;
    last_next           = 1'b1;
    ram_we              = 1'b0;
    ram_re              = 1'b0;

    case (state)
      frf_pkg::ST_IDLE: begin
        if (in_take) begin
          if (phase == frf_pkg::PH_WAIT) begin
            // Hunt for the header run; ticks are ignored
            if (action == frf_pkg::ACT_BYTE) begin
              header_run_next = (rx_byte == frf_pkg::HDR_CHAR) ? header_run + 1'b1 : '0;
              if (header_run_next == HdrCount) begin
                phase_next         = frf_pkg::PH_READ;
                header_run_next    = '0;
                byte_position_next = '0;
                running_sum_next   = 8'd0;
                tick_count_next    = '0;
              end
            end
          end else if (action == frf_pkg::ACT_TICK) begin
            // Count ticks and drop the frame on timeout
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              load_out           = 1'b1;
              frame_status_next  = frf_pkg::STAT_TIMEOUT;
              phase_next         = frf_pkg::PH_WAIT;
              header_run_next    = '0;
              byte_position_next = '0;
              tick_count_next    = '0;
            end
          end else if (byte_position == '0) begin
            // Check the length byte
            frame_length_next = rx_byte;
            if (rx_byte < len_lo || rx_byte > len_hi) begin
              load_out           = 1'b1;
              frame_status_next  = frf_pkg::STAT_LEN_ERR;
              phase_next         = frf_pkg::PH_WAIT;
              header_run_next    = '0;
              byte_position_next = '0;
              tick_count_next    = '0;
            end else begin
              running_sum_next   = rx_byte;
              byte_position_next = frf_pkg::POS_W'(1);
            end
          end else begin
            // Store the byte and accumulate the checksum
            ram_we             = store_idx < StoreDepthPos;
            byte_position_next = pos_inc;
            if (store_idx == '0) begin
              src_reg_next = rx_byte;
            end
            if (store_idx == frf_pkg::POS_W'(1)) begin
              dst_reg_next = rx_byte;
            end
            if ({2'b00, pos_inc} < frame_length) begin
              running_sum_next = running_sum + rx_byte;
            end else begin
              // Frame complete: judge checksum and destination
              phase_next         = frf_pkg::PH_WAIT;
              header_run_next    = '0;
              byte_position_next = '0;
              tick_count_next    = '0;
              plen_reg_next      = plen_calc;
              src_address_next    = src_reg;
              dest_address_next   = dst_reg;
              payload_length_next = plen_calc[4:0];
              if (running_sum != rx_byte) begin
                load_out          = 1'b1;
                frame_status_next = frf_pkg::STAT_SUM_ERR;
              end else if (dst_reg != own_address && dst_reg != frf_pkg::BROADCAST) begin
                load_out          = 1'b1;
                frame_status_next = frf_pkg::STAT_NOT_HERE;
              end else if (plen_calc == '0) begin
                load_out          = 1'b1;
                frame_status_next = frf_pkg::STAT_OK;
              end else begin
                rd_addr_next    = AddrW'(2);
                emit_count_next = plen_calc;
                state_next      = frf_pkg::ST_READ;
              end
            end
          end
        end
      end
      frf_pkg::ST_READ: begin
        // Fetch the next payload byte
        ram_re          = 1'b1;
        rd_addr_next    = rd_addr + 1'b1;
        emit_count_next = emit_count - 1'b1;
        state_next      = frf_pkg::ST_LOAD;
      end
      frf_pkg::ST_LOAD: begin
        // Hand the fetched byte to the output register
        if (out_free) begin
          load_out            = 1'b1;
          payload_byte_next   = ram_rdata;
          is_payload_next     = 1'b1;
          src_address_next    = src_reg;
          dest_address_next   = dst_reg;
          payload_length_next = plen_reg[4:0];
          last_next           = 1'b0;
          state_next = (emit_count == '0) ? frf_pkg::ST_STATUS : frf_pkg::ST_READ;
        end
      end
      frf_pkg::ST_STATUS: begin
        // Close the run with the accepted status
        if (out_free) begin
          load_out            = 1'b1;
          src_address_next    = src_reg;
          dest_address_next   = dst_reg;
          payload_length_next = plen_reg[4:0];
          frame_status_next   = frf_pkg::STAT_OK;
          state_next          = frf_pkg::ST_IDLE;
        end
      end
      default: state_next = frf_pkg::ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= frf_pkg::ST_IDLE;
      phase         <= frf_pkg::PH_WAIT;
      header_run    <= '0;
      frame_length  <= '0;
      byte_position <= '0;
      running_sum   <= 8'd0;
      tick_count    <= '0;
      rd_addr       <= '0;
      emit_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      header_run    <= header_run_next;
      frame_length  <= frame_length_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      tick_count    <= tick_count_next;
      rd_addr       <= rd_addr_next;
      emit_count    <= emit_count_next;
      out_valid     <= out_valid_next;
    end
  end

  // Frame fields and output payload
  always_ff @(posedge clk) begin
    src_reg  <= src_reg_next;
    dst_reg  <= dst_reg_next;
    plen_reg <= plen_reg_next;
    if (load_out) begin
      payload_byte   <= payload_byte_next;
      is_payload     <= is_payload_next;
      src_address    <= src_address_next;
      dest_address   <= dest_address_next;
      payload_length <= payload_length_next;
      frame_status   <= frame_status_next;
      last           <= last_next;
    end
  end

  frf_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(rx_byte),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Emission runs only after the frame has closed
  `ASSERT_CLK(a_emit_after_close, clk, rst, (state != frf_pkg::ST_IDLE) |-> (phase == frf_pkg::PH_WAIT), "payload run while still reading a frame")
  // Every RAM fetch is followed by its load
  `ASSERT_CLK(a_read_then_load, clk, rst, (state == frf_pkg::ST_READ) |=> (state == frf_pkg::ST_LOAD), "fetched byte not loaded")
  // A fetch always has a payload byte left to deliver
  `ASSERT_CLK(a_read_count, clk, rst, (state == frf_pkg::ST_READ) |-> (emit_count != '0), "fetch past the end of the payload")
  // Payload items never close a run
  `ASSERT_CLK(a_payload_not_last, clk, rst, (out_valid && is_payload) |-> !last, "payload item marked last")

endmodule

[tb/tb_frame_receiver_with_address_filter_top.sv]
`timescale 1ns / 100ps

module tb_frame_receiver_with_address_filter_top;

  localparam int HDR_COUNT   = frf_pkg::HEADER_COUNT_DEF;
  localparam int MAX_FRM     = frf_pkg::MAX_FRAME_DEF;
  localparam int STORE_DEPTH = MAX_FRM - 1;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 100000;

  typedef struct {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic [7:0] src_address;
    logic [7:0] dest_address;
    logic [4:0] payload_length;
    logic [2:0] frame_status;
    logic       last;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = frf_pkg::ACT_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        is_payload;
  logic [7:0]  src_address;
  logic [7:0]  dest_address;
  logic [4:0]  payload_length;
  logic [2:0]  frame_status;
  logic        last;

  // register shadow
  logic [7:0]  cfg_own     = frf_pkg::OWN_ADDR_RST;
  logic [5:0]  cfg_min     = frf_pkg::MIN_LEN_RST;
  logic [5:0]  cfg_max     = frf_pkg::MAX_LEN_RST;
  logic [15:0] cfg_timeout = frf_pkg::TIMEOUT_RST;

  // receiver state as predicted
  frf_pkg::phase_t rx_phase = frf_pkg::PH_WAIT;
  logic [2:0]  hdr_run  = '0;
  logic [7:0]  flen     = '0;
  logic [5:0]  bpos     = '0;
  logic [7:0]  fstore [STORE_DEPTH];
  logic [7:0]  csum     = '0;
  logic [15:0] ticks    = '0;

  rx_item_t expected_items[$];

  int fail_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int status_count [5];
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int hold_off_req = 0;

  frame_receiver_with_address_filter_top DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .is_payload     (is_payload),
    .src_address    (src_address),
    .dest_address   (dest_address),
    .payload_length (payload_length),
    .frame_status   (frame_status),
    .last           (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Frame receiver prediction
  function automatic void push_item(input logic [7:0] pb, input logic isp,
                                    input logic [7:0] src, input logic [7:0] dst,
                                    input logic [4:0] plen, input logic [2:0] st,
                                    input logic lst);
    rx_item_t it;
    it.payload_byte   = pb;
    it.is_payload     = isp;
    it.src_address    = src;
    it.dest_address   = dst;
    it.payload_length = plen;
    it.frame_status   = st;
    it.last           = lst;
    expected_items.push_back(it);
  endfunction

  function automatic void return_to_wait();
    rx_phase = frf_pkg::PH_WAIT;
    hdr_run  = '0;
    bpos     = '0;
    ticks    = '0;
  endfunction

  function automatic void predict_receiver(input logic act, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] src;
    logic [7:0] dst;
    logic [4:0] plen;
    logic [5:0] idx;
    // hunt for the header run
    if (rx_phase != frf_pkg::PH_READ) begin
      if (act != frf_pkg::ACT_BYTE) return;
      hdr_run = (b == frf_pkg::HDR_CHAR) ? hdr_run + 3'd1 : 3'd0;
      if (hdr_run == HDR_COUNT) begin
        rx_phase = frf_pkg::PH_READ;
        hdr_run  = '0;
        bpos     = '0;
        csum     = '0;
        ticks    = '0;
      end
      return;
    end
    // count ticks toward the frame timeout
    if (act == frf_pkg::ACT_TICK) begin
      if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
      if (ticks >= cfg_timeout) begin
        push_item(8'd0, 1'b0, 8'd0, 8'd0, 5'd0, frf_pkg::STAT_TIMEOUT, 1'b1);
        return_to_wait();
      end
      return;
    end
    // length byte
    if (bpos == 0) begin
      lo   = (cfg_min < frf_pkg::MIN_LEN) ? frf_pkg::MIN_LEN : 8'(cfg_min);
      hi   = (cfg_max > MAX_FRM) ? 8'(MAX_FRM) : 8'(cfg_max);
      flen = b;
      if (b < lo || b > hi) begin
        push_item(8'd0, 1'b0, 8'd0, 8'd0, 5'd0, frf_pkg::STAT_LEN_ERR, 1'b1);
        return_to_wait();
        return;
      end
      csum = b;
      bpos = 6'd1;
      return;
    end
    // store the frame byte
    idx = bpos - 6'd1;
    if (idx < STORE_DEPTH) fstore[idx] = b;
    bpos = bpos + 6'd1;
    if (bpos < flen) begin
      csum = csum + b;
      return;
    end
    // frame complete, b is the checksum
    src  = fstore[0];
    dst  = fstore[1];
    plen = 5'(flen - 8'd4);
    if (csum != b) begin
      push_item(8'd0, 1'b0, src, dst, plen, frf_pkg::STAT_SUM_ERR, 1'b1);
    end else if (dst != cfg_own && dst != frf_pkg::BROADCAST) begin
      push_item(8'd0, 1'b0, src, dst, plen, frf_pkg::STAT_NOT_HERE, 1'b1);
    end else begin
      for (int i = 0; i < plen; i++)
        push_item(fstore[i + 2], 1'b1, src, dst, plen, frf_pkg::STAT_OK, 1'b0);
      push_item(8'd0, 1'b0, src, dst, plen, frf_pkg::STAT_OK, 1'b1);
    end
    return_to_wait();
  endfunction

  // Send one transaction, with bursts and random gaps
  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(rx_phase == frf_pkg::PH_WAIT && act == frf_pkg::ACT_TICK)) items_sent++;
    predict_receiver(act, b);
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(1, 100) <= pct)
      send_item(frf_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Header, length, source, destination, payload, checksum
  task automatic send_frame(input logic [7:0] len, input logic [7:0] dst,
                            input bit bad_sum, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    repeat (HDR_COUNT) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
    maybe_tick(tick_pct);
    send_item(frf_pkg::ACT_BYTE, len);
    sum = len;
    i = 1;
    while (i < len && rx_phase == frf_pkg::PH_READ) begin
      if (i == 1)
        b = 8'($urandom_range(0, 255));
      else if (i == 2)
        b = dst;
      else if (i == len - 1)
        b = sum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'd0);
      else if ($urandom_range(0, 3) == 0)
        b = frf_pkg::HDR_CHAR;
      else
        b = 8'($urandom_range(0, 255));
      send_item(frf_pkg::ACT_BYTE, b);
      sum = sum + b;
      i++;
      if (i < len) maybe_tick(tick_pct);
    end
  endtask

  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(4, 10));
    return 8'($urandom_range(4, MAX_FRM));
  endfunction

  function automatic logic [7:0] pick_dest();
    case ($urandom_range(0, 3))
      0, 1:    return cfg_own;
      2:       return frf_pkg::BROADCAST;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Finish any open frame with zero bytes
  task automatic close_frame();
    while (rx_phase == frf_pkg::PH_READ) send_item(frf_pkg::ACT_BYTE, 8'h00);
  endtask

  // Hold the input until every pending result has arrived
  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (expected_items.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_items.size() != 0) begin
      $error("%0d expected results never arrived", expected_items.size());
      fail_count++;
      expected_items.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write over the configuration port, block idle
  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    close_frame();
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      frf_pkg::REG_OWN_ADDR: cfg_own     = value[7:0];
      frf_pkg::REG_MIN_LEN:  cfg_min     = value[5:0];
      frf_pkg::REG_MAX_LEN:  cfg_max     = value[5:0];
      frf_pkg::REG_TIMEOUT:  cfg_timeout = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: long hold-offs on request, otherwise a changing stall pattern
  initial begin : rx_side
    int mode;
    int span;
    int pat_left;
    int cyc;
    mode     = 0;
    pat_left = 0;
    cyc      = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req != 0) begin
        span         = hold_off_req;
        hold_off_req = 0;
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          mode     = $urandom_range(0, 3);
          pat_left = $urandom_range(8, 64);
        end
        pat_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (cyc % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    rx_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_items.size() == 0) begin
        $error("unexpected result: payload_byte %0h is_payload %0d status %0d",
               payload_byte, is_payload, frame_status);
        fail_count++;
      end else begin
        want = expected_items.pop_front();
        check_field("payload_byte", want.payload_byte, payload_byte);
        check_field("is_payload", want.is_payload, is_payload);
        check_field("src_address", want.src_address, src_address);
        check_field("dest_address", want.dest_address, dest_address);
        check_field("payload_length", want.payload_length, payload_length);
        check_field("frame_status", want.frame_status, frame_status);
        check_field("last", want.last, last);
        results_seen++;
        if (!is_payload && frame_status <= frf_pkg::STAT_TIMEOUT)
          status_count[frame_status]++;
      end
    end
  end

  // Short directed checks with reset settings
  task automatic test_directed_basics();
    // ticks while waiting are dropped
    send_item(frf_pkg::ACT_TICK, 8'hFF);
    send_item(frf_pkg::ACT_TICK, 8'h00);
    // four header bytes then a break: no frame
    repeat (HDR_COUNT - 1) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
    send_item(frf_pkg::ACT_BYTE, 8'h41);
    // shortest payload frame to own address, extreme byte values
    repeat (HDR_COUNT) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
    send_item(frf_pkg::ACT_BYTE, 8'd5);
    send_item(frf_pkg::ACT_BYTE, 8'h00);
    send_item(frf_pkg::ACT_BYTE, 8'h00);
    send_item(frf_pkg::ACT_BYTE, 8'hFF);
    send_item(frf_pkg::ACT_BYTE, 8'(8'd5 + 8'hFF));
    // length byte at the top of its range
    repeat (HDR_COUNT) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
    send_item(frf_pkg::ACT_BYTE, 8'hFF);
    wait_drained();
  endtask

  // Destination filtering across own address settings
  task automatic test_address_filter();
    logic [7:0] owns [3];
    owns[0] = 8'h00;
    owns[1] = frf_pkg::BROADCAST;
    owns[2] = 8'($urandom_range(1, 254));
    foreach (owns[k]) begin
      set_register(frf_pkg::REG_OWN_ADDR, 32'(owns[k]));
      repeat (2) send_frame(pick_len(), pick_dest(), $urandom_range(0, 5) == 0, 0);
    end
    set_register(frf_pkg::REG_OWN_ADDR, 32'($urandom_range(0, 255)));
  endtask

  // Length limits at and around their bounds
  task automatic test_length_limits();
    int lims [4][2];
    logic [7:0] l;
    lims[0] = '{4, 32};
    lims[1] = '{32, 32};
    lims[2] = '{4, 4};
    lims[3] = '{20, 10};
    for (int k = 0; k < 4; k++) begin
      set_register(frf_pkg::REG_MIN_LEN, 32'(lims[k][0]));
      set_register(frf_pkg::REG_MAX_LEN, 32'(lims[k][1]));
      for (int j = 0; j < 4; j++) begin
        case (j)
          0:       l = 8'(lims[k][0] - 1);
          1:       l = 8'(lims[k][0]);
          2:       l = 8'(lims[k][1] + 1);
          default: l = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(33, 255));
        endcase
        send_frame(l, pick_dest(), 1'b0, 0);
      end
      // a sixth header byte becomes the length byte
      repeat (HDR_COUNT + 1) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
    end
    set_register(frf_pkg::REG_MIN_LEN, 32'(frf_pkg::MIN_LEN_RST));
    set_register(frf_pkg::REG_MAX_LEN, 32'(frf_pkg::MAX_LEN_RST));
  endtask

  // Ticks inside frames, from the shortest timeout to the longest
  task automatic test_timeouts();
    set_register(frf_pkg::REG_TIMEOUT, 32'd1);
    repeat (2) send_frame(pick_len(), cfg_own, 1'b0, 100);
    send_frame(8'd6, cfg_own, 1'b0, 0);
    set_register(frf_pkg::REG_TIMEOUT, 32'd3);
    repeat (3) send_frame(pick_len(), pick_dest(), 1'b0, 25);
    set_register(frf_pkg::REG_TIMEOUT, 32'd65535);
    send_frame(pick_len(), pick_dest(), 1'b0, 40);
    set_register(frf_pkg::REG_TIMEOUT, 32'(frf_pkg::TIMEOUT_RST));
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off_req = 400;
    send_frame(8'd10, cfg_own, 1'b0, 0);
    send_frame(8'd8, frf_pkg::BROADCAST, 1'b0, 0);
    send_frame(8'd6, cfg_own, 1'b1, 0);
    // pause the sender until all results are in
    wait_drained();
    gaps_on = 1'b1;
    send_frame(8'(MAX_FRM), cfg_own, 1'b0, 0);
    send_frame(8'd4, frf_pkg::BROADCAST, 1'b0, 0);
    wait_drained();
  endtask

  // Mostly well-formed frames, with noise and broken frames mixed in
  task automatic test_random_traffic(input int target);
    int pick;
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_len(), pick_dest(), $urandom_range(0, 6) == 0, $urandom_range(0, 8));
      end else if (pick < 80) begin
        // truncated frame, later bytes land inside it
        repeat (HDR_COUNT) send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
        repeat ($urandom_range(0, 4))
          send_item(frf_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // partial header
        repeat ($urandom_range(1, HDR_COUNT - 1))
          send_item(frf_pkg::ACT_BYTE, frf_pkg::HDR_CHAR);
        send_item(frf_pkg::ACT_BYTE, 8'($urandom_range(0, 34)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    gaps_on = 1'b1;
    close_frame();
    wait_drained();
  endtask

  initial begin : main
    foreach (fstore[i]) fstore[i] = '0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_address_filter();
    test_length_limits();
    test_timeouts();
    test_backpressure();
    test_random_traffic(40);

    close_frame();
    wait_drained();
    $display("Sent %0d input transactions, checked %0d results.", items_sent, results_seen);
    $display("Closing status counts: ok %0d, not here %0d, length %0d, checksum %0d, timeout %0d",
             status_count[frf_pkg::STAT_OK], status_count[frf_pkg::STAT_NOT_HERE],
             status_count[frf_pkg::STAT_LEN_ERR], status_count[frf_pkg::STAT_SUM_ERR],
             status_count[frf_pkg::STAT_TIMEOUT]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
